// ----- hw/rtl/kwm_pkg.sv -----
package kwm_pkg;

   localparam int MAX_CHUNKS = 16;

   localparam int KEY_W   = 64;
   localparam int LEN_W   = 32;
   localparam int CHUNK_W = 4;
   localparam int ACT_W   = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd4096;

   typedef enum logic {
      CSR_ACTIVE_CHUNKS = 1'b0,
      CSR_MAX_LENGTH    = 1'b1
   } csr_index_type;

   // whether the minimum search found a winner, handed back to the top level
   typedef struct packed {
      logic found;
   } tree_status_type;

endpackage

// ----- hw/rtl/kwm_min_tree.sv -----
module kwm_min_tree import kwm_pkg::*; #(
   parameter int N = 16
) (
   input  logic [N-1:0]             cand_valid,
   input  logic [N-1:0][KEY_W-1:0]  cand_key,
   output tree_status_type          status,
   output logic [$clog2(N)-1:0]     win_idx
);

   localparam int IDX_W = $clog2(N);
   localparam int P     = 1 << IDX_W;

   logic [IDX_W:0][P-1:0]             node_valid;
   logic [IDX_W:0][P-1:0][KEY_W-1:0]  node_key;
   logic [IDX_W:0][P-1:0][IDX_W-1:0]  node_idx;

   // pairwise tree, lower index wins on equal keys
   always_comb begin
      node_valid = '0;
      node_key   = '0;
      node_idx   = '0;
      for (int i = 0; i < P; i++) begin
         if (i < N) begin
            node_valid[0][i] = cand_valid[i];
            node_key[0][i]   = cand_key[i];
         end
         node_idx[0][i] = IDX_W'(i);
      end
      for (int l = 0; l < IDX_W; l++) begin
         for (int j = 0; j < P / 2; j++) begin
            if (node_valid[l][2*j] &&
                (!node_valid[l][2*j+1] || node_key[l][2*j] <= node_key[l][2*j+1])) begin
               node_valid[l+1][j] = node_valid[l][2*j];
               node_key[l+1][j]   = node_key[l][2*j];
               node_idx[l+1][j]   = node_idx[l][2*j];
            end else begin
               node_valid[l+1][j] = node_valid[l][2*j+1];
               node_key[l+1][j]   = node_key[l][2*j+1];
               node_idx[l+1][j]   = node_idx[l][2*j+1];
            end
         end
      end
   end

   assign status.found = node_valid[IDX_W][0];
   assign win_idx      = node_idx[IDX_W][0];

endmodule

// ----- hw/rtl/kway_sorted_merge.sv -----
// channel | ports                                   | handshake
// --------+-----------------------------------------+------------------------------
// request | req_source_chunk/record_key/...         | start & !busy, busy always low
// result  | rsp_out_key/out_length/out_chunk/...    | rsp_valid strobe, one cycle
// csr     | csr_index, csr_wdata                    | csr_valid & csr_ready
//
// one item per cycle; from acceptance to result: an input register,
// then head update plus one comparator tree over all heads into the result register.
// the tree over MAX_CHUNKS 64-bit keys is the long path of the block.
// synchronous reset clears head present, end and valid flags and restores the CSRs.
// the receiver cannot stall; a result stands for exactly one cycle.
module kway_sorted_merge import kwm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   start,
   output logic                   busy,
   input  logic [CHUNK_W-1:0]     req_source_chunk,
   input  logic [KEY_W-1:0]       req_record_key,
   input  logic [LEN_W-1:0]       req_record_length,
   input  logic                   req_stream_ended,

   output logic                   rsp_valid,
   output logic [KEY_W-1:0]       rsp_out_key,
   output logic [LEN_W-1:0]       rsp_out_length,
   output logic [CHUNK_W-1:0]     rsp_out_chunk,
   output logic                   rsp_finished,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_CHUNKS);
   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam int CMP_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

   // configuration registers
   logic [ACT_W-1:0] active_ff;
   logic [LEN_W-1:0] max_len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= ACTIVE_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ACTIVE_CHUNKS: active_ff  <= csr_wdata[ACT_W-1:0];
            CSR_MAX_LENGTH:    max_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [CHUNK_W-1:0]  src_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [LEN_W-1:0]    len_ff;
   logic                ends_ff;

   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_valid_in) begin
         src_ff  <= req_source_chunk;
         key_ff  <= req_record_key;
         len_ff  <= req_record_length;
         ends_ff <= req_stream_ended;
      end
   end

   // head store
   logic [MAX_CHUNKS-1:0][KEY_W-1:0] head_key_ff;
   logic [MAX_CHUNKS-1:0][LEN_W-1:0] head_len_ff;
   logic [MAX_CHUNKS-1:0]            present_ff, present_in;
   logic [MAX_CHUNKS-1:0]            ended_ff, ended_in;

   logic [CMP_W-1:0]                 count;
   logic [MAX_CHUNKS-1:0]            in_merge;
   logic [MAX_CHUNKS-1:0]            wr_head;
   logic [MAX_CHUNKS-1:0]            p_after, e_after;
   logic [MAX_CHUNKS-1:0][KEY_W-1:0] key_after;
   logic [MAX_CHUNKS-1:0][LEN_W-1:0] len_after;
   logic [MAX_CHUNKS-1:0]            cand_valid;
   logic                             record_bad;
   logic                             all_ready;
   logic                             fire;

   tree_status_type  tree_status;
   logic [IDX_W-1:0] win_idx;

   always_comb begin
      count = CMP_W'(active_ff);
      if (count == '0) begin
         count = CMP_W'(1);
      end
      if (count > CMP_W'(MAX_CHUNKS)) begin
         count = CMP_W'(MAX_CHUNKS);
      end

      record_bad = ends_ff || (len_ff == '0) || (len_ff > max_len_ff);
      all_ready  = 1'b1;

      for (int i = 0; i < MAX_CHUNKS; i++) begin
         logic hit;
         in_merge[i] = CMP_W'(i) < count;
         hit = in_valid_ff && (CMP_W'(src_ff) == CMP_W'(i)) && in_merge[i]
               && !present_ff[i] && !ended_ff[i];
         wr_head[i]   = hit && !record_bad;
         p_after[i]   = present_ff[i] || wr_head[i];
         e_after[i]   = ended_ff[i] || (hit && record_bad);
         key_after[i] = wr_head[i] ? key_ff : head_key_ff[i];
         len_after[i] = wr_head[i] ? len_ff : head_len_ff[i];
         cand_valid[i] = p_after[i] && in_merge[i];
         if (in_merge[i] && !p_after[i] && !e_after[i]) begin
            all_ready = 1'b0;
         end
      end
   end

   kwm_min_tree #(
      .N (MAX_CHUNKS)
   ) u_min_tree (
      .cand_valid (cand_valid),
      .cand_key   (key_after),
      .status     (tree_status),
      .win_idx    (win_idx)
   );

   assign fire = in_valid_ff && all_ready;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [CHUNK_W-1:0] rsp_chunk_ff, rsp_chunk_in;
   logic               rsp_fin_ff, rsp_fin_in;

   always_comb begin
      present_in   = p_after;
      ended_in     = e_after;
      rsp_valid_in = fire;
      rsp_key_in   = '0;
      rsp_len_in   = '0;
      rsp_chunk_in = '0;
      rsp_fin_in   = 1'b0;
      if (fire) begin
         if (tree_status.found) begin
            rsp_key_in   = key_after[win_idx];
            rsp_len_in   = len_after[win_idx];
            rsp_chunk_in = CHUNK_W'(win_idx);
            present_in[win_idx] = 1'b0;
         end else begin
            // every chunk drained: report once and start over
            rsp_fin_in = 1'b1;
            present_in = '0;
            ended_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         ended_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         if (wr_head[i]) begin
            head_key_ff[i] <= key_ff;
            head_len_ff[i] <= len_ff;
         end
      end
      rsp_key_ff   <= rsp_key_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_chunk_ff <= rsp_chunk_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_key    = rsp_key_ff;
   assign rsp_out_length = rsp_len_ff;
   assign rsp_out_chunk  = rsp_chunk_ff;
   assign rsp_finished   = rsp_fin_ff;

   // finished result leaves the merge state empty
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fin_ff) |-> (present_ff == '0 && ended_ff == '0))
      else $error("merge state not cleared on finish");

   // a result is only ever caused by an item in the input register
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(in_valid_ff))
      else $error("result without an item");

   // heads and end flags change only when an item is processed
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> ($stable(present_ff) && $stable(ended_ff)))
      else $error("merge state changed without an item");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import kwm_pkg::*;

   localparam int CHUNKS      = MAX_CHUNKS;
   localparam int LATENCY     = 4;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   length;
      logic [CHUNK_W-1:0] chunk;
      logic               finished;
   } merge_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CHUNK_W-1:0]    req_source_chunk = '0;
   logic [KEY_W-1:0]      req_record_key = '0;
   logic [LEN_W-1:0]      req_record_length = '0;
   logic                  req_stream_ended = 1'b0;
   logic                  rsp_valid;
   logic [KEY_W-1:0]      rsp_out_key;
   logic [LEN_W-1:0]      rsp_out_length;
   logic [CHUNK_W-1:0]    rsp_out_chunk;
   logic                  rsp_finished;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_ACTIVE_CHUNKS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // mirror of the merge state and registers
   logic [KEY_W-1:0] held_key [CHUNKS];
   logic [LEN_W-1:0] held_length [CHUNKS];
   bit               held_valid [CHUNKS];
   bit               chunk_done [CHUNKS];
   logic [ACT_W-1:0] active_setting = ACTIVE_RESET;
   logic [LEN_W-1:0] max_length_setting = MAX_LEN_RESET;

   merge_result_type pending_results [$];

   int failures = 0;
   int records_taken = 0;
   int results_seen = 0;
   int merges_done = 0;
   int settings_used = 0;
   int sender_idle_pct = 0;
   int cycle_count = 0;

   kway_sorted_merge DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_source_chunk  (req_source_chunk),
      .req_record_key    (req_record_key),
      .req_record_length (req_record_length),
      .req_stream_ended  (req_stream_ended),
      .rsp_valid         (rsp_valid),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_length    (rsp_out_length),
      .rsp_out_chunk     (rsp_out_chunk),
      .rsp_finished      (rsp_finished),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function automatic int merge_width();
      if (active_setting == 0) return 1;
      if (active_setting > CHUNKS) return CHUNKS;
      return int'(active_setting);
   endfunction

   function automatic void clear_heads();
      for (int i = 0; i < CHUNKS; i++) begin
         held_key[i] = '0;
         held_length[i] = '0;
         held_valid[i] = 1'b0;
         chunk_done[i] = 1'b0;
      end
   endfunction

   // applies one item to the mirror; returns 1 when the item was not ignored
   function automatic bit advance_merge(input logic [CHUNK_W-1:0] chunk,
                                        input logic [KEY_W-1:0] key,
                                        input logic [LEN_W-1:0] length,
                                        input logic ends);
      int n;
      int best;
      bit found;
      bit taken;
      merge_result_type res;
      n = merge_width();
      taken = 1'b0;
      found = 1'b0;
      best = 0;
      if (chunk < n && !held_valid[chunk] && !chunk_done[chunk]) begin
         taken = 1'b1;
         if (ends || length == 0 || length > max_length_setting) begin
            chunk_done[chunk] = 1'b1;
         end else begin
            held_key[chunk] = key;
            held_length[chunk] = length;
            held_valid[chunk] = 1'b1;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (!held_valid[i] && !chunk_done[i]) return taken;
      end
      // strict compare keeps the lowest chunk on equal keys
      for (int i = 0; i < n; i++) begin
         if (held_valid[i] && (!found || held_key[i] < held_key[best])) begin
            best = i;
            found = 1'b1;
         end
      end
      if (found) begin
         res.key = held_key[best];
         res.length = held_length[best];
         res.chunk = CHUNK_W'(best);
         res.finished = 1'b0;
         held_valid[best] = 1'b0;
      end else begin
         res = '0;
         res.finished = 1'b1;
         clear_heads();
         merges_done++;
      end
      pending_results.push_back(res);
      return taken;
   endfunction

   task automatic send_item(input logic [CHUNK_W-1:0] chunk, input logic [KEY_W-1:0] key,
                            input logic [LEN_W-1:0] length, input logic ends);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_source_chunk <= chunk;
      req_record_key <= key;
      req_record_length <= length;
      req_stream_ended <= ends;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (advance_merge(chunk, key, length, ends)) records_taken++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic configure(input logic [ACT_W-1:0] active, input logic [LEN_W-1:0] max_len,
                            input logic [CSR_DATA_W-1:0] filler);
      wait_idle();
      // upper data bits are outside the count field and carry noise
      csr_valid <= 1'b1;
      csr_index <= CSR_ACTIVE_CHUNKS;
      csr_wdata <= {filler[CSR_DATA_W-1:ACT_W], active};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      active_setting = active;
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= max_len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      max_length_setting = max_len;
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   always @(posedge clock) begin
      merge_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: chunk %0d key %h", rsp_out_chunk, rsp_out_key);
            failures++;
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (rsp_out_key !== want.key) begin
               $error("out_key: expected %h, got %h", want.key, rsp_out_key);
               failures++;
            end
            if (rsp_out_length !== want.length) begin
               $error("out_length: expected %h, got %h", want.length, rsp_out_length);
               failures++;
            end
            if (rsp_out_chunk !== want.chunk) begin
               $error("out_chunk: expected %0d, got %0d", want.chunk, rsp_out_chunk);
               failures++;
            end
            if (rsp_finished !== want.finished) begin
               $error("finished: expected %b, got %b", want.finished, rsp_finished);
               failures++;
            end
         end
      end
   end

   // registers still at their reset values: sixteen chunks, length limit 4096
   task automatic test_default_registers();
      send_item(0, 64'h10, 32'd4096, 1'b0);
      send_item(1, 64'h5, 32'd4097, 1'b0);
      send_item(2, 64'h3, 32'd0, 1'b0);
      for (int c = 3; c < CHUNKS; c++) begin
         send_item(CHUNK_W'(c), ~64'(c), $urandom, 1'b1);
      end
      send_item(0, '0, 32'd1, 1'b1);
   endtask

   task automatic test_key_extremes();
      configure(5'd3, '1, $urandom);
      send_item(0, '1, '1, 1'b0);
      send_item(1, '0, 32'd1, 1'b0);
      // occupied slot and a chunk outside the merge are both ignored
      send_item(1, 64'h7, 32'd9, 1'b0);
      send_item(15, '0, 32'd2, 1'b0);
      // equal keys: chunk 1 goes first
      send_item(2, '0, 32'd2, 1'b0);
      send_item(1, '0, '0, 1'b1);
      send_item(1, 64'h1, 32'd3, 1'b0);
      send_item(2, '0, 32'd5, 1'b1);
      send_item(0, '0, '0, 1'b0);
   endtask

   // count of zero acts as one chunk, and no record fits a zero limit
   task automatic test_zero_max_length();
      configure(5'd0, '0, $urandom);
      send_item(1, 64'h99, 32'd7, 1'b0);
      send_item(0, 64'h1234, 32'd5, 1'b0);
   endtask

   // producer behaviour: sorted keys per chunk, refill whichever slot is open
   task automatic run_merge_session(input int budget);
      int remaining [CHUNKS];
      logic [KEY_W-1:0] last_key [CHUNKS];
      logic [KEY_W-1:0] step;
      logic [KEY_W-1:0] next_key;
      logic [LEN_W-1:0] length;
      int open_slots [$];
      int merges_before;
      int sent;
      int c;
      bit narrow;
      narrow = $urandom_range(1);
      merges_before = merges_done;
      for (int i = 0; i < CHUNKS; i++) begin
         remaining[i] = $urandom_range(merge_width() > 4 ? 2 : 6);
         last_key[i] = narrow ? '0 : {$urandom, $urandom} >> $urandom_range(8, 1);
      end
      sent = 0;
      while (sent < budget && merges_done == merges_before) begin
         open_slots.delete();
         for (int i = 0; i < merge_width(); i++) begin
            if (!held_valid[i] && !chunk_done[i]) open_slots.push_back(i);
         end
         if (open_slots.size() == 0 || $urandom_range(9) == 0) begin
            send_item(CHUNK_W'($urandom_range(15)), {$urandom, $urandom}, $urandom,
                      1'($urandom_range(1)));
         end else begin
            c = open_slots[$urandom_range(open_slots.size() - 1)];
            if (remaining[c] == 0) begin
               case ($urandom_range(3))
                  0: send_item(CHUNK_W'(c), {$urandom, $urandom}, '0, 1'($urandom_range(1)));
                  1: begin
                     if (max_length_setting == '1) begin
                        send_item(CHUNK_W'(c), {$urandom, $urandom}, '1, 1'b1);
                     end else begin
                        send_item(CHUNK_W'(c), {$urandom, $urandom}, max_length_setting + 1,
                                  1'b0);
                     end
                  end
                  default: send_item(CHUNK_W'(c), {$urandom, $urandom}, $urandom, 1'b1);
               endcase
            end else begin
               remaining[c]--;
               if (narrow) begin
                  step = KEY_W'($urandom_range(2));
               end else begin
                  step = {$urandom, $urandom} >> $urandom_range(63, 4);
               end
               next_key = last_key[c] + step;
               if (next_key < last_key[c]) next_key = '1;
               last_key[c] = next_key;
               if (max_length_setting == 0) begin
                  length = $urandom_range(100, 1);
               end else begin
                  case ($urandom_range(3))
                     0: length = max_length_setting;
                     1: length = 32'd1;
                     default: length = $urandom_range(max_length_setting, 1);
                  endcase
               end
               send_item(CHUNK_W'(c), next_key, length, 1'b0);
            end
         end
         sent++;
         // hold off now and then until the block has caught up
         if (sent == budget / 2 && $urandom_range(3) == 0) wait_idle();
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int target);
      int goal;
      logic [ACT_W-1:0] active;
      logic [LEN_W-1:0] max_len;
      sender_idle_pct = idle_pct;
      goal = records_taken + target;
      while (records_taken < goal) begin
         case ($urandom_range(7))
            0: active = 5'd1;
            1: active = 5'd16;
            2: active = 5'd0;
            3: active = 5'd31;
            4: active = 5'd17;
            default: active = ACT_W'($urandom_range(CHUNKS, 2));
         endcase
         case ($urandom_range(6))
            0: max_len = 32'd1;
            1: max_len = '1;
            2: max_len = '0;
            3: max_len = 32'd4096;
            4: max_len = $urandom;
            default: max_len = $urandom_range(5000, 1);
         endcase
         configure(active, max_len, $urandom);
         repeat ($urandom_range(3, 1)) run_merge_session(60);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      clear_heads();
      active_setting = ACTIVE_RESET;
      max_length_setting = MAX_LEN_RESET;

      test_default_registers();
      test_key_extremes();
      test_zero_max_length();
      test_random_traffic(14, 100);
      test_random_traffic(81, 100);
      test_random_traffic(0, 95);
      wait_idle();

      $display("merged %0d records and end markers under %0d register settings",
               records_taken, settings_used);
      $display("checked %0d results, %0d of them completed merges", results_seen, merges_done);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
